// ----- rtl/tfsa_pkg.sv -----
package tfsa_pkg;

  // Fixed field widths of the request and result beats.
  localparam int unsigned InTickW   = 32;
  localparam int unsigned SlotIdxW  = 6;
  localparam int unsigned StepW     = 7;

  // Reset value of the grow step register.
  localparam logic [StepW-1:0] GrowStepRst = 7'd1;

  // One result beat as it travels from the controller to the ports.
  typedef struct packed {
    logic [SlotIdxW-1:0] slot_index;
    logic                grew;
    logic                pool_full;
  } result_t;

endpackage

// ----- rtl/tfsa_tick_mem.sv -----
module tfsa_tick_mem
  import tfsa_pkg::*;
#(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] tick_mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      tick_mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; the read data is registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= tick_mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tfsa_ctrl.sv -----
module tfsa_ctrl
  import tfsa_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 64,
  parameter int unsigned TICK_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [StepW-1:0]             grow_step_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [InTickW-1:0]           current_tick_i,
  input  logic [InTickW-1:0]           completed_tick_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output result_t                      result_o,
  output logic                         mem_we_o,
  output logic [$clog2(MAX_SLOTS)-1:0] mem_waddr_o,
  output logic [TICK_BITS-1:0]         mem_wdata_o,
  output logic                         mem_re_o,
  output logic [$clog2(MAX_SLOTS)-1:0] mem_raddr_o,
  input  logic [TICK_BITS-1:0]         mem_rdata_i
);

  localparam int unsigned IdxW = $clog2(MAX_SLOTS);
  localparam int unsigned CapW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned SumW = ((CapW > StepW) ? CapW : StepW) + 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  state_e               state_q;
  logic [IdxW-1:0]      clr_idx_q;
  logic [CapW-1:0]      cap_q;
  logic [IdxW-1:0]      hint_q;
  logic [TICK_BITS-1:0] now_q;
  logic [TICK_BITS-1:0] done_q;
  logic [StepW-1:0]     step_q;
  logic [IdxW-1:0]      iss_idx_q;
  logic [CapW-1:0]      iss_left_q;
  logic                 cmp_vld_q;
  logic [IdxW-1:0]      cmp_idx_q;
  logic                 found_q;
  logic [IdxW-1:0]      hit_q;
  logic                 out_valid_q;
  result_t              res_q;

  logic                 cmp_hit;
  logic                 iss_go;
  logic [CapW-1:0]      iss_nxt;
  logic                 commit_go;
  logic [SumW-1:0]      grow_sum;
  logic                 grow_full;
  logic [IdxW-1:0]      sel_idx;
  logic                 do_write;
  logic [CapW-1:0]      sel_nxt;
  logic [CapW-1:0]      cap_d;
  logic [IdxW-1:0]      hint_d;

  // Scan pipeline: one read issued per cycle, its data compared in the next cycle.
  assign iss_go  = (state_q == ST_SCAN) && (iss_left_q != '0);
  assign iss_nxt = CapW'(iss_idx_q) + CapW'(1);
  assign cmp_hit = cmp_vld_q && (mem_rdata_i <= done_q);

  // Commit waits until the output register is free or drains this cycle.
  assign commit_go = (state_q == ST_COMMIT) && (!out_valid_q || out_ready_i);

  // Growth: the first new slot sits at the old capacity.
  assign grow_sum  = SumW'(cap_q) + SumW'(step_q);
  assign grow_full = grow_sum > SumW'(MAX_SLOTS);
  assign sel_idx   = found_q ? hit_q : cap_q[IdxW-1:0];
  assign do_write  = commit_go && (found_q || !grow_full);

  // The hint moves past the chosen slot and wraps at the new capacity.
  assign cap_d   = found_q ? cap_q : grow_sum[CapW-1:0];
  assign sel_nxt = CapW'(sel_idx) + CapW'(1);
  assign hint_d  = (sel_nxt == cap_d) ? '0 : sel_nxt[IdxW-1:0];

  // Memory access; the clearing pass owns the write port after reset.
  assign mem_we_o    = (state_q == ST_CLEAR) || do_write;
  assign mem_waddr_o = (state_q == ST_CLEAR) ? clr_idx_q : sel_idx;
  assign mem_wdata_o = (state_q == ST_CLEAR) ? '0 : now_q;
  assign mem_re_o    = iss_go;
  assign mem_raddr_o = iss_idx_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  // Sequencer with its state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      cap_q       <= '0;
      hint_q      <= '0;
      iss_left_q  <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_idx_q <= clr_idx_q + IdxW'(1);
          if (clr_idx_q == IdxW'(MAX_SLOTS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            now_q      <= TICK_BITS'(current_tick_i);
            done_q     <= TICK_BITS'(completed_tick_i);
            step_q     <= (grow_step_i == '0) ? StepW'(1) : grow_step_i;
            iss_idx_q  <= hint_q;
            iss_left_q <= cap_q;
            cmp_vld_q  <= 1'b0;
            found_q    <= 1'b0;
            // An empty pool has nothing to search and goes straight to commit, to grow or report full.
            state_q    <= (cap_q == '0) ? ST_COMMIT : ST_SCAN;
          end
        end
        ST_SCAN: begin
          cmp_vld_q <= iss_go;
          cmp_idx_q <= iss_idx_q;
          if (iss_go) begin
            iss_idx_q  <= (iss_nxt == cap_q) ? '0 : iss_nxt[IdxW-1:0];
            iss_left_q <= iss_left_q - CapW'(1);
          end
          if (cmp_hit) begin
            found_q   <= 1'b1;
            hit_q     <= cmp_idx_q;
            cmp_vld_q <= 1'b0;
            state_q   <= ST_COMMIT;
          end else if (!cmp_vld_q && (iss_left_q == '0)) begin
            state_q <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (commit_go) begin
            out_valid_q <= 1'b1;
            if (!found_q && grow_full) begin
              res_q.slot_index <= '0;
              res_q.grew       <= 1'b0;
              res_q.pool_full  <= 1'b1;
            end else begin
              res_q.slot_index <= SlotIdxW'(sel_idx);
              res_q.grew       <= !found_q;
              res_q.pool_full  <= 1'b0;
            end
            if (do_write) begin
              cap_q  <= cap_d;
              hint_q <= hint_d;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // The live capacity never passes the slot limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_q <= CapW'(MAX_SLOTS))
    else $error("live capacity beyond slot limit");

  // The hint points inside the live pool, or is zero while the pool is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cap_q == '0) && (hint_q == '0)) || (CapW'(hint_q) < cap_q))
    else $error("search hint outside live pool");

  // The capacity only grows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> cap_q >= $past(cap_q))
    else $error("live capacity shrank");

  // No write lands on the memory while a scan reads it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !mem_we_o)
    else $error("tick write during scan");

  // A full pool beat carries no slot and no growth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_o.pool_full) |-> (!result_o.grew && (result_o.slot_index == '0)))
    else $error("pool full beat with allocation");

endmodule

// ----- rtl/tick_fenced_slot_allocator_top.sv -----
// Slot allocator fenced by submission ticks.
// Request channel (in_valid_i/in_ready_o): one beat carries the current tick and
// the completed tick. Result channel (out_valid_o/out_ready_i): one beat per
// request with the slot index, a grew flag and a pool full flag.
// The grow step register is written through cfg_we_i/cfg_wdata_i; the user must
// write it only while the block is idle, as the block itself has no check for it.
// Scan: a request scans the live pool from the search hint, one tick entry
// per cycle out of the slot memory, and stops at the first free slot. The tick
// memory has a single read port. One request is in work at a time; the next is
// taken once the current one is committed.
// Reset: the sequencer state, capacity, hint and grow step are reset, then a
// clearing pass zeroes each tick memory entry; in_ready_o stays low during it.
// Stall: a finished result waits in the output register. A new request may be
// accepted and scanned meanwhile; it commits once the held beat is taken.
module tick_fenced_slot_allocator_top
  import tfsa_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 64,
  parameter int unsigned TICK_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [StepW-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [InTickW-1:0]  current_tick_i,
  input  logic [InTickW-1:0]  completed_tick_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SlotIdxW-1:0] slot_index_o,
  output logic                grew_o,
  output logic                pool_full_o
);

  localparam int unsigned IdxW = $clog2(MAX_SLOTS);

  logic [StepW-1:0]     grow_step_q;
  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;
  logic [TICK_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [IdxW-1:0]      mem_raddr;
  logic [TICK_BITS-1:0] mem_rdata;
  result_t              result;

  // Grow step register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grow_step_q <= GrowStepRst;
    end else if (cfg_we_i) begin
      grow_step_q <= cfg_wdata_i;
    end
  end

  tfsa_ctrl #(
    .MAX_SLOTS (MAX_SLOTS),
    .TICK_BITS (TICK_BITS)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .grow_step_i      (grow_step_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .current_tick_i   (current_tick_i),
    .completed_tick_i (completed_tick_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_o         (result),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_re_o         (mem_re),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata)
  );

  tfsa_tick_mem #(
    .DEPTH (MAX_SLOTS),
    .WIDTH (TICK_BITS)
  ) u_tick_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Result beat fields.
  assign slot_index_o = result.slot_index;
  assign grew_o       = result.grew;
  assign pool_full_o  = result.pool_full;

endmodule

// ----- sim/tick_fenced_slot_allocator_top_test.sv -----
module tick_fenced_slot_allocator_top_test
  import tfsa_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxSlots     = 64;
  localparam int unsigned TickBits     = 32;
  localparam int unsigned SettleCycles = MaxSlots + 8;
  localparam int unsigned WatchdogMax  = 4000;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [StepW-1:0]    cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [InTickW-1:0]  current_tick_i;
  logic [InTickW-1:0]  completed_tick_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [SlotIdxW-1:0] slot_index_o;
  logic                grew_o;
  logic                pool_full_o;

  // Shadow copy of the allocator state.
  logic [InTickW-1:0]  slot_tick_shadow [MaxSlots];
  int unsigned         pool_capacity;
  int unsigned         next_hint;
  logic [StepW-1:0]    grow_step_shadow;

  // Allocations accepted but not yet returned, oldest first.
  result_t             pending_allocs[$];
  int unsigned         mismatches = 0;
  int unsigned         sender_idle_pct;
  int unsigned         receiver_stall_pct;
  int unsigned         quiet_cycles;
  logic [InTickW-1:0]  submit_tick;

  tick_fenced_slot_allocator_top #(
    .MAX_SLOTS(MaxSlots),
    .TICK_BITS(TickBits)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .current_tick_i  (current_tick_i),
    .completed_tick_i(completed_tick_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .slot_index_o    (slot_index_o),
    .grew_o          (grew_o),
    .pool_full_o     (pool_full_o)
  );

  always #6 clk_i = ~clk_i;

  // Works out the slot that one request gets and updates the shadow state.
  function automatic result_t allocate_slot(input logic [InTickW-1:0] now_tick,
                                            input logic [InTickW-1:0] done_tick);
    result_t     res;
    int unsigned step;
    int unsigned hit;
    bit          found;
    res   = '0;
    hit   = 0;
    found = 1'b0;
    step  = (grow_step_shadow == '0) ? 1 : int'(grow_step_shadow);
    // Search from the hint to the end, then wrap around to the hint.
    for (int unsigned i = next_hint; i < pool_capacity && !found; i++) begin
      if (slot_tick_shadow[i] <= done_tick) begin
        hit   = i;
        found = 1'b1;
      end
    end
    for (int unsigned i = 0; i < next_hint && !found; i++) begin
      if (slot_tick_shadow[i] <= done_tick) begin
        hit   = i;
        found = 1'b1;
      end
    end
    // No free slot: grow the pool, or report it full.
    if (!found) begin
      if (pool_capacity + step > MaxSlots) begin
        res.pool_full = 1'b1;
        return res;
      end
      hit           = pool_capacity;
      pool_capacity = pool_capacity + step;
      res.grew      = 1'b1;
    end
    slot_tick_shadow[hit] = now_tick;
    next_hint             = (hit + 1) % pool_capacity;
    res.slot_index        = hit[SlotIdxW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic set_idle_mode(input idle_mode_e mode);
    case (mode)
      IDLE_SENDER: begin
        sender_idle_pct    = 56;
        receiver_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 56;
      end
      IDLE_BOTH: begin
        sender_idle_pct    = 11;
        receiver_stall_pct = 11;
      end
      default: begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
    endcase
  endtask

  // Sends one request beat, with an optional idle gap before it.
  task automatic send_request(input logic [InTickW-1:0] now_tick,
                              input logic [InTickW-1:0] done_tick);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i       <= 1'b1;
    current_tick_i   <= now_tick;
    completed_tick_i <= done_tick;
    do @(posedge clk_i); while (!in_ready_o);
    pending_allocs.push_back(allocate_slot(now_tick, done_tick));
  endtask

  // Drops the request valid and waits until every result is back.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (pending_allocs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_grow_step(input logic [StepW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i         <= 1'b0;
    grow_step_shadow  = value;
  endtask

  // A step beyond the pool limit on an empty pool leaves it full at once.
  task automatic test_oversized_step();
    write_grow_step(7'd127);
    send_request(32'd5, 32'd0);
    wait_quiet();
  endtask

  // A zero step acts as a step of one; each busy pool grows by one slot.
  task automatic test_zero_step();
    write_grow_step(7'd0);
    send_request(32'd10, 32'd0);
    send_request(32'd20, 32'd0);
    send_request(32'd30, 32'd5);
  endtask

  // Ticks at both ends of the range compare as plain unsigned numbers.
  task automatic test_tick_extremes();
    send_request(32'hFFFF_FFFF, 32'd30);
    send_request(32'd0, 32'hFFFF_FFFE);
    send_request(32'h8000_0000, 32'hFFFF_FFFF);
    send_request(32'd7, 32'd0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_quiet();
  endtask

  // A step of MAX_SLOTS overflows a non-empty pool; a step that just fits grows it to the limit.
  task automatic test_step_extremes();
    write_grow_step(7'd64);
    send_request(32'd100, 32'd0);
    wait_quiet();
    write_grow_step(7'd61);
    send_request(32'd100, 32'd0);
    send_request(32'd101, 32'd0);
    send_request(32'd102, 32'd0);
    wait_quiet();
  endtask

  // Mostly in-order submissions that retire with a random lag, plus noise.
  task automatic test_random_traffic(input idle_mode_e mode, input logic [StepW-1:0] step,
                                     input int unsigned beats, input int unsigned lag_span);
    logic [InTickW-1:0] now_tick;
    logic [InTickW-1:0] done_tick;
    int unsigned        pick;
    write_grow_step(step);
    set_idle_mode(mode);
    submit_tick = $urandom;
    repeat (beats) begin
      pick = $urandom_range(99);
      if (pick < 88) begin
        submit_tick = submit_tick + $urandom_range(1, 4);
        now_tick    = submit_tick;
        done_tick   = submit_tick - $urandom_range(0, lag_span);
      end else if (pick < 96) begin
        now_tick  = $urandom;
        done_tick = $urandom;
      end else begin
        now_tick  = submit_tick;
        done_tick = '1;
      end
      send_request(now_tick, done_tick);
    end
    wait_quiet();
    set_idle_mode(IDLE_NONE);
  endtask

  // Random backpressure on the result channel.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Compare each result beat with the oldest expected allocation.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_allocs.size() == 0) begin
        report_mismatch($sformatf("unexpected beat slot %0d grew %0b full %0b",
                                  slot_index_o, grew_o, pool_full_o));
      end else begin
        want = pending_allocs.pop_front();
        if (slot_index_o !== want.slot_index) begin
          report_mismatch($sformatf("slot_index got %0d expected %0d",
                                    slot_index_o, want.slot_index));
        end
        if (grew_o !== want.grew) begin
          report_mismatch($sformatf("grew got %0b expected %0b", grew_o, want.grew));
        end
        if (pool_full_o !== want.pool_full) begin
          report_mismatch($sformatf("pool_full got %0b expected %0b",
                                    pool_full_o, want.pool_full));
        end
      end
    end
  end

  // End the run when no beat moves on either channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogMax) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    in_valid_i       <= 1'b0;
    current_tick_i   <= '0;
    completed_tick_i <= '0;
    submit_tick       = '0;
    pool_capacity     = 0;
    next_hint         = 0;
    grow_step_shadow  = GrowStepRst;
    foreach (slot_tick_shadow[i]) slot_tick_shadow[i] = '0;
    set_idle_mode(IDLE_NONE);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_oversized_step();
    test_zero_step();
    test_tick_extremes();
    test_step_extremes();
    test_random_traffic(IDLE_NONE, 7'd1, 250, 60);
    test_random_traffic(IDLE_SENDER, 7'($urandom_range(1, 64)), 250, 200);
    test_random_traffic(IDLE_RECEIVER, 7'd64, 250, 400);
    test_random_traffic(IDLE_BOTH, 7'd0, 250, 120);
    test_random_traffic(IDLE_NONE, 7'd127, 200, 300);
    test_random_traffic(IDLE_SENDER, 7'd1, 250, 40);
    test_random_traffic(IDLE_RECEIVER, 7'($urandom_range(1, 64)), 250, 250);
    test_random_traffic(IDLE_BOTH, 7'd64, 250, 80);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tfsa_pkg.sv
rtl/tfsa_tick_mem.sv
rtl/tfsa_ctrl.sv
rtl/tick_fenced_slot_allocator_top.sv
sim/tick_fenced_slot_allocator_top_test.sv
